// File: rtl/hrsf_pkg.sv
// Shared types and constants for the human-readable size formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package hrsf_pkg;

    localparam int unsigned DIGITS_MAX    = 8;     // decimal digits of the largest whole part
    localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
    localparam int unsigned RECIP10_SHIFT = 35;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    typedef enum logic [2:0] {
        UNIT_B = 3'd0,
        UNIT_K = 3'd1,
        UNIT_M = 3'd2,
        UNIT_G = 3'd3,
        UNIT_T = 3'd4
    } t_unit;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CLASSIFY,
        FS_CONVERT,
        FS_PUSH
    } t_front_state;

    typedef enum logic {
        BS_IDLE,
        BS_EMIT
    } t_back_state;

    // one classified word: digits least significant first, count, tenth, unit
    typedef struct packed {
        logic [DIGITS_MAX-1:0][3:0] digits;
        logic [3:0]                 nd;
        logic [3:0]                 tenth;
        t_unit                      unit;
    } t_entry;

    function automatic logic [7:0] unit_letter(input t_unit u);
        logic [7:0] c;
        case (u)
            UNIT_B:  c = 8'h42;
            UNIT_K:  c = 8'h4B;
            UNIT_M:  c = 8'h4D;
            UNIT_G:  c = 8'h47;
            UNIT_T:  c = 8'h54;
            default: c = 8'h42;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hrsf_front.sv
// Front end: accepts a byte count, picks the unit, rounds the tenth digit and
// converts the whole part to decimal, one digit per cycle. Uses hrsf_pkg.
`default_nettype none

module hrsf_front #(
    parameter int SIZE_WIDTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  [63:0]         i_size_bytes,
    input  wire                 i_full,
    output logic                o_push,
    output hrsf_pkg::t_entry    o_entry
);
    import hrsf_pkg::*;

    // whole part after scaling, plus one bit for the rounding carry
    localparam int WHOLE_W = (SIZE_WIDTH > 50) ? SIZE_WIDTH - 39 : 11;
    localparam int PROD_W  = WHOLE_W + 32;

    t_front_state                r_state, n_state;
    logic [SIZE_WIDTH-1:0]       r_size, n_size;
    logic [WHOLE_W-1:0]          r_val, n_val;
    logic [3:0]                  r_nd, n_nd;
    logic [DIGITS_MAX-1:0][3:0]  r_dig, n_dig;
    logic [3:0]                  r_tenth, n_tenth;
    t_unit                       r_unit, n_unit;

    logic [63:0]         c_x;
    t_unit               c_unit;
    logic [WHOLE_W-1:0]  c_whole;
    logic [9:0]          c_rem;
    logic [13:0]         c_round;
    logic [3:0]          c_tenth;
    logic [PROD_W-1:0]   c_prod;
    logic [WHOLE_W-1:0]  c_quot;
    logic [WHOLE_W-1:0]  c_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_size  <= n_size;
        r_val   <= n_val;
        r_nd    <= n_nd;
        r_dig   <= n_dig;
        r_tenth <= n_tenth;
        r_unit  <= n_unit;
    end

    // unit selection: same result as shifting by 10 while >= 1024, up to T
    always_comb begin
        c_x = 64'(r_size);
        if (|c_x[63:40]) begin
            c_unit  = UNIT_T;
            c_whole = WHOLE_W'(c_x >> 40);
            c_rem   = c_x[39:30];
        end else if (|c_x[39:30]) begin
            c_unit  = UNIT_G;
            c_whole = WHOLE_W'(c_x >> 30);
            c_rem   = c_x[29:20];
        end else if (|c_x[29:20]) begin
            c_unit  = UNIT_M;
            c_whole = WHOLE_W'(c_x >> 20);
            c_rem   = c_x[19:10];
        end else if (|c_x[19:10]) begin
            c_unit  = UNIT_K;
            c_whole = WHOLE_W'(c_x >> 10);
            c_rem   = c_x[9:0];
        end else begin
            c_unit  = UNIT_B;
            c_whole = WHOLE_W'(c_x);
            c_rem   = 10'd0;
        end
        c_round = 14'(c_rem) * 14'd10 + 14'd512;
        c_tenth = c_round[13:10];
    end

    // divide by 10 through the reciprocal; remainder is the next digit
    always_comb begin
        c_prod = PROD_W'(r_val) * PROD_W'(RECIP10);
        c_quot = WHOLE_W'(c_prod >> RECIP10_SHIFT);
        c_diff = r_val - (c_quot << 3) - (c_quot << 1);
    end

    always_comb begin
        n_state = r_state;
        n_size  = r_size;
        n_val   = r_val;
        n_nd    = r_nd;
        n_dig   = r_dig;
        n_tenth = r_tenth;
        n_unit  = r_unit;
        busy    = 1'b1;
        o_push  = 1'b0;
        case (r_state)
            FS_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_size  = i_size_bytes[SIZE_WIDTH-1:0];
                    n_state = FS_CLASSIFY;
                end
            end
            FS_CLASSIFY: begin
                n_unit = c_unit;
                n_nd   = 4'd0;
                if (c_tenth >= 4'd10) begin
                    // rounds into the whole part, no rescale
                    n_val   = c_whole + WHOLE_W'(1);
                    n_tenth = 4'd0;
                end else begin
                    n_val   = c_whole;
                    n_tenth = c_tenth;
                end
                n_state = FS_CONVERT;
            end
            FS_CONVERT: begin
                n_dig[r_nd[2:0]] = c_diff[3:0];
                n_nd             = r_nd + 4'd1;
                n_val            = c_quot;
                if (c_quot == '0) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    // fields in the order of t_entry: digits, count, tenth, unit
    assign o_entry = {r_dig, r_nd, r_tenth, r_unit};

    a_busy_ends_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_push))
        else $error("front left busy without pushing a word");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_nd != 4'd0 && r_nd <= 4'(DIGITS_MAX)))
        else $error("pushed word with bad digit count");

endmodule

`default_nettype wire

// File: rtl/hrsf_queue.sv
// Two-entry queue of classified words between front and back end.
// Uses hrsf_pkg for the entry type.
`default_nettype none

module hrsf_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  hrsf_pkg::t_entry    i_entry,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output hrsf_pkg::t_entry    o_head
);
    import hrsf_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/hrsf_back.sv
// Back end: takes a classified word, applies the buffer-size truncation and
// sends the text out one character per cycle. Uses hrsf_pkg.
`default_nettype none

module hrsf_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [4:0]          i_buffer_size,
    input  wire                 i_empty,
    input  hrsf_pkg::t_entry    i_head,
    output logic                o_pop,
    output logic                o_char_valid,
    output logic [7:0]          o_char_code,
    output logic                o_last_char
);
    import hrsf_pkg::*;

    t_back_state  r_state, n_state;
    t_entry       r_entry, n_entry;
    logic [3:0]   r_nk, n_nk;       // digits kept after truncation
    logic         r_dot, n_dot;
    logic [3:0]   r_len, n_len;
    logic [3:0]   r_pos, n_pos;
    logic         r_valid, n_valid;
    logic [7:0]   r_char, n_char;
    logic         r_last, n_last;

    logic [4:0]   c_nd, c_lim, c_nk, c_j;
    logic         c_dot, c_ltr;
    logic [3:0]   c_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
        r_nk    <= n_nk;
        r_dot   <= n_dot;
        r_len   <= n_len;
        r_pos   <= n_pos;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    // truncation rules, evaluated on the queue head (buffer size >= 2 here)
    always_comb begin
        c_nd  = 5'(i_head.nd);
        c_lim = (i_head.unit == UNIT_B) ? i_buffer_size - 5'd2 : i_buffer_size - 5'd1;
        c_nk  = (c_nd < c_lim) ? c_nd : c_lim;
        if (i_head.unit == UNIT_B) begin
            c_dot = 1'b0;
            c_j   = c_nk;
            c_ltr = 1'b1;
        end else begin
            c_dot = (i_head.tenth != 4'd0) && (c_nk < i_buffer_size - 5'd2);
            c_j   = c_nk + (c_dot ? 5'd2 : 5'd0);
            c_ltr = (c_j < i_buffer_size - 5'd1);
        end
    end

    always_comb begin
        n_state = r_state;
        n_entry = r_entry;
        n_nk    = r_nk;
        n_dot   = r_dot;
        n_len   = r_len;
        n_pos   = r_pos;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        o_pop   = 1'b0;
        c_idx   = r_entry.nd - 4'd1 - r_pos;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    // a buffer of one or less prints nothing: drop the word
                    if (i_buffer_size > 5'd1) begin
                        n_entry = i_head;
                        n_nk    = c_nk[3:0];
                        n_dot   = c_dot;
                        n_len   = c_j[3:0] + 4'(c_ltr);
                        n_pos   = 4'd0;
                        n_state = BS_EMIT;
                    end
                end
            end
            BS_EMIT: begin
                n_valid = 1'b1;
                if (r_pos < r_nk) begin
                    n_char = {4'h3, r_entry.digits[c_idx[2:0]]};
                end else if (r_dot && r_pos == r_nk) begin
                    n_char = CHAR_DOT;
                end else if (r_dot && r_pos == r_nk + 4'd1) begin
                    n_char = CHAR_ZERO + 8'(r_entry.tenth);
                end else begin
                    n_char = unit_letter(r_entry.unit);
                end
                n_last = (r_pos == r_len - 4'd1);
                if (r_pos == r_len - 4'd1) begin
                    n_state = BS_IDLE;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    assign o_char_valid = r_valid;
    assign o_char_code  = r_char;
    assign o_last_char  = r_last;

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && o_last_char) |=> !o_char_valid)
        else $error("character strobe right after last character");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_EMIT) |-> (r_len != 4'd0 && r_len <= 4'd11 && r_pos < r_len))
        else $error("text length out of range");

endmodule

`default_nettype wire

// File: rtl/human_readable_size_formatter.sv
// Top level of the human-readable size formatter: buffer-size register, front
// end, word queue and back end. Uses hrsf_pkg, hrsf_front, hrsf_queue, hrsf_back.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   input     i_size_bytes[63:0]                       start high, busy low
//   result    o_char_code[7:0], o_last_char            o_char_valid, one cycle
//   config    i_cfg_wdata[4:0] (buffer_size)           i_cfg_we, no wait
//
// Front end: after start it classifies the word, then converts the whole part with
// the divide-by-10 unit producing one digit per cycle, and pushes it when not full.
// Back end: pops a word from the queue and sends it out one character per cycle;
// the two overlap through a two-word queue.
// Reset (synchronous, active low) empties the queue and sets buffer_size to 16.
// The receiver cannot stall; busy stays high while the front end holds a word.
`default_nettype none

module human_readable_size_formatter #(
    parameter int SIZE_WIDTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [63:0] i_size_bytes,
    input  wire         i_cfg_we,
    input  wire  [4:0]  i_cfg_wdata,
    output logic        o_char_valid,
    output logic [7:0]  o_char_code,
    output logic        o_last_char
);
    import hrsf_pkg::*;

    logic [4:0] r_buffer_size;
    logic       push, pop, full, empty;
    t_entry     push_entry, head_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= 5'd16;
        end else if (i_cfg_we) begin
            r_buffer_size <= i_cfg_wdata;
        end
    end

    hrsf_front #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_size_bytes (i_size_bytes),
        .i_full       (full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    hrsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_entry)
    );

    hrsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_buffer_size (r_buffer_size),
        .i_empty       (empty),
        .i_head        (head_entry),
        .o_pop         (pop),
        .o_char_valid  (o_char_valid),
        .o_char_code   (o_char_code),
        .o_last_char   (o_last_char)
    );

endmodule

`default_nettype wire
